>>> rtl/core/dqip_pkg.sv
package dqip_pkg;

  localparam logic [7:0] CharNul  = 8'h00;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharDot  = 8'h2E;

  localparam logic [9:0] OctetMax  = 10'd255;
  localparam logic [1:0] MaxDigits = 2'd3;
  localparam logic [1:0] LastOctet = 2'd3;

  typedef struct packed {
    logic [1:0]  octet_index;
    logic [1:0]  digit_count;
    logic [9:0]  accumulator;
    logic [23:0] octets_done;
    logic        await_end;
  } dqip_state_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] address;
    logic        ok;
  } dqip_result_t;

  localparam dqip_state_t StateReset = '{
    octet_index: 2'd0,
    digit_count: 2'd0,
    accumulator: 10'd0,
    octets_done: 24'd0,
    await_end:   1'b0
  };

endpackage

>>> rtl/core/dqip_step.sv
module dqip_step import dqip_pkg::*; (
  input  logic [7:0]   char_i,
  input  dqip_state_t  state_i,
  output dqip_state_t  state_o,
  output dqip_result_t result_o
);

  logic        is_nul;
  logic        is_dot;
  logic        is_digit;
  logic [9:0]  acc_times10;
  logic [9:0]  acc_digit;
  logic [1:0]  dc_next;
  logic        finish;
  logic        good;
  logic [9:0]  acc_final;
  dqip_state_t nxt;

  assign is_nul   = (char_i == CharNul);
  assign is_dot   = (char_i == CharDot);
  assign is_digit = (char_i >= CharZero) && (char_i <= CharNine);

  // acc*10 as shift-add, wraps at 10 bits
  assign acc_times10 = {state_i.accumulator[6:0], 3'b000} + {state_i.accumulator[8:0], 1'b0};
  assign acc_digit   = acc_times10 + {6'd0, char_i[3:0]};
  assign dc_next     = state_i.digit_count + 2'd1;

  always_comb begin
    nxt       = state_i;
    finish    = 1'b0;
    good      = 1'b0;
    acc_final = state_i.accumulator;
    if (state_i.await_end) begin
      if (is_nul) begin
        nxt = StateReset;
      end
    end else if (state_i.digit_count < MaxDigits && !is_nul && !is_dot) begin
      if (!is_digit) begin
        finish = 1'b1;
      end else begin
        nxt.accumulator = acc_digit;
        nxt.digit_count = dc_next;
        acc_final       = acc_digit;
        if (dc_next == MaxDigits) begin
          if (acc_digit > OctetMax) begin
            finish = 1'b1;
          end else if (state_i.octet_index == LastOctet) begin
            finish = 1'b1;
            good   = 1'b1;
          end
        end
      end
    end else begin
      // current octet ends on this character
      if (state_i.accumulator > OctetMax) begin
        finish = 1'b1;
      end else if (state_i.octet_index == LastOctet) begin
        finish = 1'b1;
        good   = 1'b1;
      end else if (!is_dot) begin
        finish = 1'b1;
      end else begin
        unique case (state_i.octet_index)
          2'd0:    nxt.octets_done[7:0]   = state_i.octets_done[7:0]
                                            | state_i.accumulator[7:0];
          2'd1:    nxt.octets_done[15:8]  = state_i.octets_done[15:8]
                                            | state_i.accumulator[7:0];
          default: nxt.octets_done[23:16] = state_i.octets_done[23:16]
                                            | state_i.accumulator[7:0];
        endcase
        nxt.octet_index = state_i.octet_index + 2'd1;
        nxt.digit_count = 2'd0;
        nxt.accumulator = 10'd0;
      end
    end

    if (finish) begin
      if (is_nul) begin
        nxt = StateReset;
      end else begin
        nxt.await_end = 1'b1;
      end
    end
  end

  assign state_o          = nxt;
  assign result_o.emit    = finish;
  assign result_o.ok      = good;
  assign result_o.address = good ? {acc_final[7:0], state_i.octets_done} : 32'd0;

endmodule

>>> rtl/core/dotted_quad_ipv4_parser.sv
// Streaming IPv4 dotted-decimal parser. Feed the string one byte per
// transaction on char_in_i, terminated by a NUL byte. Each string yields
// exactly one result transaction (address_o with the first octet in bits
// 7:0, ok_o set on success, address 0 on failure), issued on the byte
// where the outcome is decided; later bytes are swallowed until the NUL,
// which returns the parser to its reset state. One byte is accepted every
// clock cycle: the per-byte update is a single multiply-by-ten accumulate
// and compare between the parser state registers, and results land in a
// two-entry output queue, so the input only stalls when both entries are
// waiting on the downstream side. A result is registered into the output
// queue when the byte that decides it is accepted.
module dotted_quad_ipv4_parser import dqip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] address_o,
  output logic        ok_o
);

  dqip_state_t  state_q, state_d;
  dqip_result_t step_res;
  logic [32:0]  head_q, head_d;
  logic [32:0]  tail_q, tail_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         accept;
  logic         push;
  logic         pop;

  dqip_step u_step (
    .char_i   (char_in_i),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  assign in_stall_o = (cnt_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && step_res.emit;
  assign pop        = (cnt_q != 2'd0) && !out_stall_i;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    unique case (cnt_q)
      2'd0: begin
        if (push) begin
          head_d = {step_res.address, step_res.ok};
          cnt_d  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_d = {step_res.address, step_res.ok};
        end else if (push) begin
          tail_d = {step_res.address, step_res.ok};
          cnt_d  = 2'd2;
        end else if (pop) begin
          cnt_d = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_d = tail_q;
          cnt_d  = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
      cnt_q   <= 2'd0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign address_o   = head_q[32:1];
  assign ok_o        = head_q[0];

endmodule

>>> rtl/core/dqip_checker.sv
module dqip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  char_in_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] address_o,
  input logic        ok_o
);

  // output transaction held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(address_o) && $stable(ok_o))
    else $error("result changed while stalled");

  // input only backs up when results are waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_valid_o))
    else $error("input stalled with no pending result");

  // a new result only follows an accepted input byte
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without input transaction");

  // failed parse reports a zero address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> address_o == 32'd0)
    else $error("failed parse with nonzero address");

endmodule

bind dotted_quad_ipv4_parser dqip_checker u_dqip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .char_in_i   (char_in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .address_o   (address_o),
  .ok_o        (ok_o)
);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench import dqip_pkg::*; ();

  localparam int ItemTarget     = 1550;
  localparam int CalmTail       = 150;
  localparam int LongHoldCycles = 80;
  localparam int WatchdogLimit  = 2000;
  localparam int Radix          = 10;

  typedef struct packed {
    logic [31:0] address;
    logic        ok;
  } parse_result_t;

  // drain set: not a byte, the sender waits here until all results are in
  typedef struct packed {
    logic       drain;
    logic [7:0] ch;
  } feed_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_in_i   = CharNul;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] address_o;
  logic        ok_o;

  feed_t         char_feed[$];
  parse_result_t result_expect[$];
  logic [7:0]    word_buf[$];

  // parser state as predicted
  logic [1:0]  cur_octet;
  logic [1:0]  cur_digits;
  logic [9:0]  cur_value;
  logic [23:0] done_octets;
  logic        await_nul;

  int error_count   = 0;
  int strings_sent  = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int ok_seen       = 0;
  int idle_cycles   = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  bit calm          = 1'b0;
  bit long_hold_done = 1'b0;
  feed_t         feed_head;
  parse_result_t want;

  dotted_quad_ipv4_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_in_i   (char_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .address_o   (address_o),
    .ok_o        (ok_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_parse();
    cur_octet   = '0;
    cur_digits  = '0;
    cur_value   = '0;
    done_octets = '0;
    await_nul   = 1'b0;
  endfunction

  function automatic void close_string(input logic [7:0] ch, input logic good);
    parse_result_t r;
    r.ok      = good;
    r.address = good ? {cur_value[7:0], done_octets} : 32'd0;
    result_expect.push_back(r);
    if (ch == CharNul) clear_parse();
    else await_nul = 1'b1;
  endfunction

  function automatic void parse_char(input logic [7:0] ch);
    int v;
    if (await_nul) begin
      if (ch == CharNul) clear_parse();
    end else if (cur_digits < MaxDigits && ch != CharNul && ch != CharDot) begin
      if (ch < CharZero || ch > CharNine) begin
        close_string(ch, 1'b0);
      end else begin
        v = int'(cur_value) * Radix + int'(ch - CharZero);
        cur_value  = v[9:0];
        cur_digits = cur_digits + 2'd1;
        // third digit: range check and fourth-octet completion are immediate
        if (cur_digits == MaxDigits) begin
          if (cur_value > OctetMax) close_string(ch, 1'b0);
          else if (cur_octet == LastOctet) close_string(ch, 1'b1);
        end
      end
    end else if (cur_value > OctetMax) begin
      close_string(ch, 1'b0);
    end else if (cur_octet == LastOctet) begin
      close_string(ch, 1'b1);
    end else if (ch != CharDot) begin
      close_string(ch, 1'b0);
    end else begin
      done_octets = done_octets | (24'(cur_value) << (8 * cur_octet));
      cur_octet   = cur_octet + 2'd1;
      cur_digits  = '0;
      cur_value   = '0;
    end
  endfunction

  function automatic logic [7:0] junk_byte();
    case ($urandom_range(0, 3))
      0: junk_byte = CharZero + 8'($urandom_range(0, 9));
      1: junk_byte = CharDot;
      default: junk_byte = 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    feed_t f;
    f.drain = 1'b0;
    f.ch    = b;
    char_feed.push_back(f);
  endtask

  task automatic push_pause();
    feed_t f;
    f.drain = 1'b1;
    f.ch    = CharNul;
    char_feed.push_back(f);
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_byte(s[i]);
    push_byte(CharNul);
    strings_sent++;
  endtask

  task automatic append_octet();
    int mode, val, width, len, div;
    mode = $urandom_range(0, 19);
    val  = 0;
    if (mode == 0) begin
      width = 0;
    end else if (mode == 1) begin
      val   = $urandom_range(256, 999);
      width = 3;
    end else if (mode == 2) begin
      val   = $urandom_range(1000, 9999);
      width = 4;
    end else begin
      if (mode < 6) val = $urandom_range(0, 1) ? 255 : 0;
      else val = $urandom_range(0, 255);
      len   = (val >= 100) ? 3 : (val >= 10) ? 2 : 1;
      // sometimes pad with leading zeros
      width = ($urandom_range(0, 3) == 0) ? $urandom_range(len, 3) : len;
    end
    for (int i = width - 1; i >= 0; i--) begin
      div = 1;
      repeat (i) div *= 10;
      word_buf.push_back(CharZero + 8'((val / div) % 10));
    end
  endtask

  task automatic push_random_string();
    int kind, n, pos;
    word_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(0, 12);
      repeat (n) word_buf.push_back(junk_byte());
    end else begin
      for (int k = 0; k < 4; k++) begin
        append_octet();
        if (k < 3) word_buf.push_back(CharDot);
      end
      case ($urandom_range(0, 5))
        0: begin
          word_buf.push_back(CharDot);
          repeat ($urandom_range(0, 4)) word_buf.push_back(junk_byte());
        end
        1: repeat ($urandom_range(1, 4)) word_buf.push_back(junk_byte());
        default: ;
      endcase
      if (kind >= 80 && word_buf.size() > 0) begin
        pos = $urandom_range(0, word_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: word_buf[pos] = 8'($urandom_range(1, 255));
          1: word_buf.delete(pos);
          default: while (word_buf.size() > pos) void'(word_buf.pop_back());
        endcase
      end
    end
    foreach (word_buf[i]) push_byte(word_buf[i]);
    push_byte(CharNul);
    strings_sent++;
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      char_in_i  <= CharNul;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_char(char_in_i);
        bytes_sent++;
      end
      if (char_feed.size() < CalmTail) calm = 1'b1;
      if (in_valid_i && in_stall_o) begin
        // hold the stalled transaction as is
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (char_feed.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (char_feed[0].drain) begin
        in_valid_i <= 1'b0;
        if (result_expect.size() == 0) void'(char_feed.pop_front());
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else begin
        feed_head = char_feed.pop_front();
        in_valid_i <= 1'b1;
        char_in_i  <= feed_head.ch;
      end
    end
  end

  // receiver and result check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (result_expect.size() == 0) begin
          $error("unexpected result: address %h ok %b", address_o, ok_o);
          error_count++;
        end else begin
          want = result_expect.pop_front();
          if (address_o !== want.address) begin
            $error("address: expected %h, actual %h", want.address, address_o);
            error_count++;
          end
          if (ok_o !== want.ok) begin
            $error("ok: expected %b, actual %b", want.ok, ok_o);
            error_count++;
          end
          if (want.ok) ok_seen++;
        end
      end
      // one long back-pressure stretch so the output queue fills up
      if (!long_hold_done && results_seen >= 30) begin
        long_hold_done = 1'b1;
        stall_left = LongHoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    clear_parse();

    push_text("0.0.0.0");
    push_text("255.255.255.255");
    push_text("1.2.3.4");
    push_text("192.168.001.010");
    push_text("");
    push_text("...");
    push_text("1..2.3");
    push_text("1.2.3.");
    push_text("256.1.1.1");
    push_text("1.2.3.999");
    push_text("25a.1.1.1");
    push_text("1.2.3.4x");
    push_text("1234.5.6.7");
    push_text("1.2.3");
    push_text("10.20.30.40.50");
    push_text("1.2.3.123abc");
    push_text("/.:");
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(CharNul);
    strings_sent++;
    push_pause();

    while (char_feed.size() < ItemTarget) begin
      push_random_string();
      if (char_feed.size() > ItemTarget / 2 && char_feed.size() < ItemTarget / 2 + 16)
        push_pause();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_feed.size() != 0 || in_valid_i) @(posedge clk_i);
    while (result_expect.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d strings in %0d bytes; checked %0d results, %0d of them valid addresses.",
             strings_sent, bytes_sent, results_seen, ok_seen);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
